// ===== sv/ps2_set3_key_matrix_host_unit_defines.svh =====
// Assertion macros for the checker file of the keyboard host unit.
// No dependencies; include by bare file name.
`ifndef PS2_SET3_KEY_MATRIX_HOST_UNIT_DEFINES_SVH
`define PS2_SET3_KEY_MATRIX_HOST_UNIT_DEFINES_SVH

// Clocked assertion, disabled while the active-low reset is asserted
`define PS2S3_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset
`define PS2S3_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== sv/ps2s3_pkg.sv =====
// Shared types and constants of the set 3 keyboard host unit.
// No dependencies.
package ps2s3_pkg;

  // Item kinds
  localparam logic [1:0] KindPoll = 2'd0;
  localparam logic [1:0] KindResp = 2'd1;
  localparam logic [1:0] KindRead = 2'd2;

  // Link phase codes
  localparam logic [2:0] PhaseReset  = 3'd0;
  localparam logic [2:0] PhaseReply  = 3'd1;
  localparam logic [2:0] PhaseId0    = 3'd2;
  localparam logic [2:0] PhaseId1    = 3'd3;
  localparam logic [2:0] PhaseConfig = 3'd4;
  localparam logic [2:0] PhaseReady  = 3'd5;
  localparam logic [2:0] PhaseBreak  = 3'd6;

  // Command and response bytes
  localparam logic [7:0] CmdReset  = 8'hFF;
  localparam logic [7:0] CmdSetAll = 8'hF8;
  localparam logic [7:0] RspAck    = 8'hFA;
  localparam logic [7:0] RspBatOk  = 8'hAA;
  localparam logic [7:0] CodeBreak = 8'hF0;
  localparam logic [7:0] CodeLimit = 8'h88;

  // Key bitmap update request from the link sequencer
  typedef struct packed {
    logic       wr;
    logic       set;
    logic [7:0] code;
  } key_cmd_t;

endpackage

// ===== sv/ps2s3_in_stage.sv =====
// Input register of the keyboard host unit: one transaction deep.
// Depends on nothing but the shared handshake convention.
module ps2s3_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] rx_byte_i,
  input  logic [4:0] row_index_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [1:0] kind_o,
  output logic [7:0] rx_byte_o,
  output logic [4:0] row_index_o
);

  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] rx_byte_q;
  logic [4:0] row_index_q;

  // Take a new transaction whenever the held one leaves or the stage is empty
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture payload on acceptance
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q      <= kind_i;
      rx_byte_q   <= rx_byte_i;
      row_index_q <= row_index_i;
    end
  end

  assign valid_o     = valid_q;
  assign kind_o      = kind_q;
  assign rx_byte_o   = rx_byte_q;
  assign row_index_o = row_index_q;

endmodule

// ===== sv/ps2s3_link_fsm.sv =====
// Link bring-up and key tracking sequencer of the keyboard host unit.
// Depends on ps2s3_pkg for kinds, phase codes, bytes and key_cmd_t.
module ps2s3_link_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          rx_byte_i,
  output logic [2:0]          phase_o,
  output logic                send_valid_o,
  output logic [7:0]          send_byte_o,
  output logic                bad_code_o,
  output ps2s3_pkg::key_cmd_t key_cmd_o
);

  typedef enum logic [2:0] {
    StReset  = ps2s3_pkg::PhaseReset,
    StReply  = ps2s3_pkg::PhaseReply,
    StId0    = ps2s3_pkg::PhaseId0,
    StId1    = ps2s3_pkg::PhaseId1,
    StConfig = ps2s3_pkg::PhaseConfig,
    StReady  = ps2s3_pkg::PhaseReady,
    StBreak  = ps2s3_pkg::PhaseBreak
  } state_e;

  state_e state_q, state_d;
  logic   nonzero;
  logic   is_key;

  assign nonzero = (rx_byte_i != 8'h00);
  assign is_key  = (rx_byte_i < ps2s3_pkg::CodeLimit);

  // Next phase and per-item outputs
  always_comb begin
    state_d        = state_q;
    send_valid_o   = 1'b0;
    send_byte_o    = 8'h00;
    bad_code_o     = 1'b0;
    key_cmd_o.wr   = 1'b0;
    key_cmd_o.set  = 1'b0;
    key_cmd_o.code = rx_byte_i;
    unique case (kind_i)
      ps2s3_pkg::KindPoll: begin
        unique case (state_q)
          StReset: begin
            send_valid_o = 1'b1;
            send_byte_o  = ps2s3_pkg::CmdReset;
          end
          StReply: begin
            if (rx_byte_i == ps2s3_pkg::RspBatOk) begin
              state_d = StId0;
            end else if (nonzero) begin
              state_d = StReset;
            end
          end
          StId0: begin
            if (nonzero) state_d = StId1;
          end
          StId1: begin
            if (nonzero) state_d = StConfig;
          end
          StConfig: begin
            send_valid_o = 1'b1;
            send_byte_o  = ps2s3_pkg::CmdSetAll;
          end
          StReady: begin
            if (rx_byte_i == ps2s3_pkg::CodeBreak) begin
              state_d = StBreak;
            end else if (nonzero) begin
              key_cmd_o.wr  = is_key;
              key_cmd_o.set = 1'b1;
              bad_code_o    = !is_key;
            end
          end
          StBreak: begin
            if (nonzero) begin
              key_cmd_o.wr = is_key;
              bad_code_o   = !is_key;
              state_d      = StReady;
            end
          end
          default: state_d = StReset;
        endcase
      end
      ps2s3_pkg::KindResp: begin
        if (rx_byte_i == ps2s3_pkg::RspAck) begin
          if (state_q == StReset) begin
            state_d = StReply;
          end else if (state_q == StConfig) begin
            state_d = StReady;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance the phase once per processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StReset;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign phase_o = state_d;

endmodule

// ===== sv/ps2s3_key_map.sv =====
// Key bitmap of the keyboard host unit: ROWS rows of eight key bits.
// Depends on ps2s3_pkg for key_cmd_t.
module ps2s3_key_map #(
  parameter int ROWS = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ps2s3_pkg::key_cmd_t key_cmd_i,
  input  logic [4:0]          rd_index_i,
  output logic [7:0]          rd_data_o
);

  localparam int         RowW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [5:0] RowsLim = 6'(ROWS);

  logic [7:0] rows_q [ROWS];
  logic [4:0] wr_row;
  logic       wr_hit;
  logic       rd_hit;
  logic [7:0] wr_mask;

  // Code splits into row (upper bits) and column (low three bits)
  assign wr_row  = key_cmd_i.code[7:3];
  assign wr_mask = 8'h01 << key_cmd_i.code[2:0];
  assign wr_hit  = step_i && key_cmd_i.wr && ({1'b0, wr_row} < RowsLim);
  assign rd_hit  = ({1'b0, rd_index_i} < RowsLim);

  // Set or clear one key bit; drop codes beyond the last row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        rows_q[r] <= 8'h00;
      end
    end else if (wr_hit) begin
      if (key_cmd_i.set) begin
        rows_q[wr_row[RowW-1:0]] <= rows_q[wr_row[RowW-1:0]] | wr_mask;
      end else begin
        rows_q[wr_row[RowW-1:0]] <= rows_q[wr_row[RowW-1:0]] & ~wr_mask;
      end
    end
  end

  // Out-of-range rows read zero
  assign rd_data_o = rd_hit ? rows_q[rd_index_i[RowW-1:0]] : 8'h00;

endmodule

// ===== sv/ps2_set3_key_matrix_host_unit.sv =====
// Top level of the set 3 keyboard host unit: input register, sequencer,
// key bitmap and result register. Depends on ps2s3_pkg and the submodules.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+----------------------------------
//   in      | input     | in_valid_i / in_ready_o | kind, rx_byte, row_index
//   out     | output    | out_valid_o/out_ready_i | send_valid, send_byte, row_bits,
//           |           |                         | link_phase, bad_code
//
// Throughput: one transaction per cycle while out_ready_i stays high. A transaction
// passes the input register and the result register around the single-pass sequencer logic.
// Reset clears the link phase, the key bitmap and both valid flags at once.
// With out_ready_i low the result holds; one more transaction waits in the
// input register, and then in_ready_o drops.
module ps2_set3_key_matrix_host_unit #(
  parameter int ROWS = 17
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] rx_byte_i,
  input  logic [4:0] row_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       send_valid_o,
  output logic [7:0] send_byte_o,
  output logic [7:0] row_bits_o,
  output logic [2:0] link_phase_o,
  output logic       bad_code_o
);

  logic                valid_s;
  logic [1:0]          kind_s;
  logic [7:0]          byte_s;
  logic [4:0]          index_s;
  logic                advance;
  logic [2:0]          phase_d;
  logic                send_valid_d;
  logic [7:0]          send_byte_d;
  logic                bad_d;
  ps2s3_pkg::key_cmd_t key_cmd;
  logic [7:0]          rd_data;
  logic [7:0]          row_bits_d;

  logic                out_valid_q;
  logic                send_valid_q;
  logic [7:0]          send_byte_q;
  logic [7:0]          row_bits_q;
  logic [2:0]          link_phase_q;
  logic                bad_code_q;

  // Move the held transaction into the result register when there is room
  assign advance = valid_s && (!out_valid_q || out_ready_i);

  ps2s3_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .rx_byte_i   (rx_byte_i),
    .row_index_i (row_index_i),
    .advance_i   (advance),
    .valid_o     (valid_s),
    .kind_o      (kind_s),
    .rx_byte_o   (byte_s),
    .row_index_o (index_s)
  );

  ps2s3_link_fsm u_link_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .kind_i       (kind_s),
    .rx_byte_i    (byte_s),
    .phase_o      (phase_d),
    .send_valid_o (send_valid_d),
    .send_byte_o  (send_byte_d),
    .bad_code_o   (bad_d),
    .key_cmd_o    (key_cmd)
  );

  ps2s3_key_map #(
    .ROWS (ROWS)
  ) u_key_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .key_cmd_i  (key_cmd),
    .rd_index_i (index_s),
    .rd_data_o  (rd_data)
  );

  // Row data only goes out for row reads
  assign row_bits_d = (kind_s == ps2s3_pkg::KindRead) ? rd_data : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      send_valid_q <= send_valid_d;
      send_byte_q  <= send_byte_d;
      row_bits_q   <= row_bits_d;
      link_phase_q <= phase_d;
      bad_code_q   <= bad_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign send_valid_o = send_valid_q;
  assign send_byte_o  = send_byte_q;
  assign row_bits_o   = row_bits_q;
  assign link_phase_o = link_phase_q;
  assign bad_code_o   = bad_code_q;

endmodule

// ===== sv/ps2s3_checker.sv =====
// Port-level checks of the set 3 keyboard host unit, bound to its top level.
// Depends on ps2s3_pkg and ps2_set3_key_matrix_host_unit_defines.svh.
`include "ps2_set3_key_matrix_host_unit_defines.svh"

module ps2s3_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       send_valid_o,
  input logic [7:0] send_byte_o,
  input logic [7:0] row_bits_o,
  input logic [2:0] link_phase_o,
  input logic       bad_code_o
);

  // Stalled result transaction holds
  `PS2S3_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(send_byte_o) && $stable(row_bits_o) && $stable(link_phase_o))

  // Command requests only come from the reset and config phases
  `PS2S3_ASSERT(a_send_phase, clk_i, rst_ni, out_valid_o && send_valid_o |-> (send_byte_o == ps2s3_pkg::CmdReset && link_phase_o == ps2s3_pkg::PhaseReset) || (send_byte_o == ps2s3_pkg::CmdSetAll && link_phase_o == ps2s3_pkg::PhaseConfig))

  // No command byte without a request
  `PS2S3_ASSERT(a_send_idle, clk_i, rst_ni, out_valid_o && !send_valid_o |-> send_byte_o == 8'h00)

  // A bad code always leaves the link ready and carries nothing else
  `PS2S3_ASSERT(a_bad_ready, clk_i, rst_ni, out_valid_o && bad_code_o |-> link_phase_o == ps2s3_pkg::PhaseReady && !send_valid_o && row_bits_o == 8'h00)

  // No result is shown coming out of reset
  `PS2S3_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind ps2_set3_key_matrix_host_unit ps2s3_checker u_ps2s3_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .send_valid_o (send_valid_o),
  .send_byte_o  (send_byte_o),
  .row_bits_o   (row_bits_o),
  .link_phase_o (link_phase_o),
  .bad_code_o   (bad_code_o)
);

// ===== tb/ps2s3_host_tb_pkg.sv =====
// Scoreboard of the set 3 keyboard host unit testbench: link phase and key
// bitmap tracking, and a queue of expected results. Depends on ps2s3_pkg.
package ps2s3_host_tb_pkg;
  import ps2s3_pkg::*;

  // Bitmap rows of the unit under test
  localparam int KeyRows = 17;

  // Unused item kind, carried by the two-bit kind field anyway
  localparam logic [1:0] KindSpare = 2'd3;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [7:0] row_bits;
    logic [2:0] link_phase;
    logic       bad_code;
  } host_result_t;

  class key_matrix_scoreboard;
    logic [2:0]   phase_q;
    logic [7:0]   key_rows[KeyRows];
    host_result_t result_q[$];
    int unsigned  mismatch_cnt;

    function new();
      phase_q = PhaseReset;
      foreach (key_rows[i]) key_rows[i] = '0;
      mismatch_cnt = 0;
    endfunction

    function logic [2:0] link_phase();
      return phase_q;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    function int unsigned failures();
      return mismatch_cnt;
    endfunction

    // Set or clear the bitmap bit a make/break code points at
    function void update_key(input logic [7:0] code, input logic on);
      if (int'(code[7:3]) < KeyRows) key_rows[code[7:3]][code[2:0]] = on;
    endfunction

    // Advance the link state by one accepted transaction and queue its result
    function void note_item(input logic [1:0] kind, input logic [7:0] rx,
                            input logic [4:0] row);
      host_result_t res;
      res = '0;
      case (kind)
        KindPoll: begin
          case (phase_q)
            PhaseReset: begin
              res.send_valid = 1'b1;
              res.send_byte  = CmdReset;
            end
            PhaseReply: begin
              if (rx == RspBatOk) phase_q = PhaseId0;
              else if (rx != 8'h00) phase_q = PhaseReset;
            end
            PhaseId0: if (rx != 8'h00) phase_q = PhaseId1;
            PhaseId1: if (rx != 8'h00) phase_q = PhaseConfig;
            PhaseConfig: begin
              res.send_valid = 1'b1;
              res.send_byte  = CmdSetAll;
            end
            PhaseReady: begin
              if (rx == CodeBreak) phase_q = PhaseBreak;
              else if (rx != 8'h00) begin
                if (rx < CodeLimit) update_key(rx, 1'b1);
                else res.bad_code = 1'b1;
              end
            end
            PhaseBreak: begin
              if (rx != 8'h00) begin
                if (rx < CodeLimit) update_key(rx, 1'b0);
                else res.bad_code = 1'b1;
                phase_q = PhaseReady;
              end
            end
            default: phase_q = PhaseReset;
          endcase
        end
        KindResp: begin
          if (rx == RspAck) begin
            if (phase_q == PhaseReset) phase_q = PhaseReply;
            else if (phase_q == PhaseConfig) phase_q = PhaseReady;
          end
        end
        KindRead: if (int'(row) < KeyRows) res.row_bits = key_rows[row];
        default: ;
      endcase
      res.link_phase = phase_q;
      result_q.push_back(res);
    endfunction

    // Compare one output transaction with the oldest expectation
    function void check_result(input host_result_t got);
      host_result_t want;
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: sv=%0d sb=%02h rb=%02h ph=%0d bad=%0d",
                   got.send_valid, got.send_byte, got.row_bits, got.link_phase,
                   got.bad_code);
        return;
      end
      want = result_q.pop_front();
      if (got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
          got.row_bits !== want.row_bits || got.link_phase !== want.link_phase ||
          got.bad_code !== want.bad_code) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch: exp sv=%0d sb=%02h rb=%02h ph=%0d bad=%0d, got sv=%0d sb=%02h rb=%02h ph=%0d bad=%0d",
                   want.send_valid, want.send_byte, want.row_bits, want.link_phase,
                   want.bad_code, got.send_valid, got.send_byte, got.row_bits,
                   got.link_phase, got.bad_code);
      end
    endfunction
  endclass

endpackage

// ===== tb/ps2_set3_key_matrix_host_unit_tb.sv =====
// Top of the set 3 keyboard host unit testbench: clock, reset, drivers and
// stimulus. Depends on ps2s3_pkg, ps2s3_host_tb_pkg and the unit RTL.
module ps2_set3_key_matrix_host_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2s3_pkg::*;
  import ps2s3_host_tb_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] kind_i      = KindPoll;
  logic [7:0] rx_byte_i   = 8'h00;
  logic [4:0] row_index_i = 5'd0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       send_valid_o;
  logic [7:0] send_byte_o;
  logic [7:0] row_bits_o;
  logic [2:0] link_phase_o;
  logic       bad_code_o;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  key_matrix_scoreboard sb = new();

  ps2_set3_key_matrix_host_unit #(
    .ROWS(KeyRows)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .rx_byte_i   (rx_byte_i),
    .row_index_i (row_index_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .send_valid_o(send_valid_o),
    .send_byte_o (send_byte_o),
    .row_bits_o  (row_bits_o),
    .link_phase_o(link_phase_o),
    .bad_code_o  (bad_code_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check each output transaction, then pick the next ready level
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result('{send_valid_o, send_byte_o, row_bits_o, link_phase_o, bad_code_o});
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Offer one input transaction after a random gap and hold it until taken
  task automatic push_item(input logic [1:0] kind, input logic [7:0] rx,
                           input logic [4:0] row);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    rx_byte_i   <= rx;
    row_index_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(kind, rx, row);
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Draw one transaction shaped by the current link phase
  task automatic random_item(output bit counts);
    logic [1:0]  kind;
    logic [7:0]  rx;
    logic [4:0]  row;
    int unsigned r;
    kind = KindPoll;
    rx   = 8'($urandom_range(0, 255));
    row  = 5'($urandom_range(0, 31));
    r    = $urandom_range(0, 99);
    case (sb.link_phase())
      PhaseReady: begin
        if (r < 45) rx = 8'($urandom_range(1, int'(CodeLimit) - 1));
        else if (r < 60) rx = CodeBreak;
        else if (r < 80) begin
          kind = KindRead;
          row  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(KeyRows, 31))
                                             : 5'($urandom_range(0, KeyRows - 1));
        end else if (r < 87) rx = 8'($urandom_range(int'(CodeLimit), 255));
        else if (r < 92) rx = 8'h00;
        else if (r < 97) begin
          kind = KindResp;
          if (r < 94) rx = RspAck;
        end else kind = KindSpare;
      end
      PhaseBreak: begin
        if (r < 75) rx = 8'($urandom_range(1, int'(CodeLimit) - 1));
        else if (r < 85) rx = CodeBreak;
        else if (r < 95) rx = 8'($urandom_range(int'(CodeLimit), 255));
        else rx = 8'h00;
      end
      PhaseReset, PhaseConfig: begin
        if (r < 50) begin
          kind = KindResp;
          if (r < 35) rx = RspAck;
        end
      end
      PhaseReply: if (r < 70) rx = RspBatOk;
      default: ;
    endcase
    counts = (kind == KindRead) || (kind == KindPoll && rx != 8'h00);
    push_item(kind, rx, row);
  endtask

  initial begin
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    int unsigned live_cnt;
    bit          counts;
    idle_set  = '{0, 69, 0, 7};
    stall_set = '{0, 0, 69, 7};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the link bring-up, including a failed self test and a non-ack response
    push_item(KindRead, 8'h00, 5'd5);
    push_item(KindPoll, 8'h3C, 5'd0);
    push_item(KindResp, 8'hFE, 5'd0);
    push_item(KindResp, RspAck, 5'd0);
    push_item(KindPoll, 8'h00, 5'd0);
    push_item(KindPoll, 8'h55, 5'd0);
    push_item(KindResp, RspAck, 5'd0);
    push_item(KindPoll, RspBatOk, 5'd0);
    push_item(KindPoll, 8'hFF, 5'd0);
    push_item(KindPoll, 8'h01, 5'd0);
    push_item(KindPoll, 8'h00, 5'd0);
    push_item(KindResp, RspAck, 5'd0);
    // Track keys: top code, zero byte, reads in and out of range, bad codes
    push_item(KindSpare, 8'hFF, 5'd31);
    push_item(KindPoll, 8'h87, 5'd0);
    push_item(KindPoll, 8'h00, 5'd0);
    push_item(KindRead, 8'h00, 5'd16);
    push_item(KindRead, 8'h00, 5'd31);
    push_item(KindPoll, CodeLimit, 5'd0);
    push_item(KindPoll, CodeBreak, 5'd0);
    push_item(KindPoll, 8'h00, 5'd0);
    push_item(KindPoll, CodeBreak, 5'd0);
    push_item(KindPoll, CodeBreak, 5'd0);
    push_item(KindPoll, 8'h87, 5'd0);
    push_item(KindRead, 8'h00, 5'd16);
    drain();

    // Random traffic under each idling mix, draining between mixes
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      live_cnt  = 0;
      while (live_cnt < 150) begin
        random_item(counts);
        if (counts) live_cnt++;
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.failures() == 0 && sb.pending() == 0) begin
      $display("ps2_set3_key_matrix_host_unit regression: pass");
    end else begin
      $display("ps2_set3_key_matrix_host_unit regression: fail");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("ps2_set3_key_matrix_host_unit regression: fail");
    $finish;
  end

endmodule
